// ----- hdl/bbcm_pkg.sv -----
// ----------------------------------------------------------------------------
// bbcm_pkg
// Shared types and constants for the block buffer cache manager.
// ----------------------------------------------------------------------------
package bbcm_pkg;

   localparam int ENTRIES_DEF = 64;
   localparam int FUNC_W      = 3;
   localparam int DEV_W       = 16;
   localparam int BLK_W       = 32;
   localparam int SLOT_W      = 6;
   localparam int REF_W       = 8;

   localparam logic [REF_W-1:0] REF_MAX = '1;

   // request function codes
   localparam logic [FUNC_W-1:0] FN_LOOKUP  = 3'd0;
   localparam logic [FUNC_W-1:0] FN_RELEASE = 3'd1;
   localparam logic [FUNC_W-1:0] FN_DIRTY   = 3'd2;
   localparam logic [FUNC_W-1:0] FN_START   = 3'd3;
   localparam logic [FUNC_W-1:0] FN_FINISH  = 3'd4;
   localparam logic [FUNC_W-1:0] FN_DISCARD = 3'd5;
   localparam logic [FUNC_W-1:0] FN_INVAL   = 3'd6;

   typedef enum logic [2:0] {
      RS_HIT, RS_CLAIMED, RS_NO_FREE, RS_BUSY,
      RS_DIRTY, RS_MISUSE, RS_NOTHING, RS_DONE
   } rstat_type;

   typedef struct packed {
      logic busy;
      logic dirty;
      logic valid;
   } flags_type;

   typedef struct packed {
      rstat_type         status;
      logic [SLOT_W-1:0] slot;
      logic              valid;
      logic              busy;
      logic [DEV_W-1:0]  vdev;
      logic [BLK_W-1:0]  vblk;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_DISPATCH, ST_FIND, ST_INV2, ST_SLOT_RD, ST_SLOT_EX,
      ST_WALK_RD, ST_WALK_EV, ST_WALK_END, ST_MV1, ST_MV2, ST_MV3, ST_MV4, ST_RESP
   } state_type;

   typedef struct packed {
      logic ready;
      logic load;
      logic clear;
      logic dispatch;
      logic find;
      logic inv2;
      logic slot_rd;
      logic slot_ex;
      logic walk_rd;
      logic walk_ev;
      logic walk_end;
      logic mv1;
      logic mv2;
      logic mv3;
      logic mv4;
      logic resp;
   } cmd_type;

   typedef struct packed {
      logic              clear_last;
      logic [FUNC_W-1:0] func;
      logic              bad_slot;
      logic              dev_zero;
      logic              scan_hit;
      logic              scan_last;
      logic              walk_stop;
      logic              claim;
      logic              rsp_free;
   } sts_type;

endpackage

// ----- hdl/bbcm_ctrl.sv -----
// ----------------------------------------------------------------------------
// bbcm_ctrl
// Sequencer for the cache manager: clearing pass, scans, ring walk, relink.
// ----------------------------------------------------------------------------
module bbcm_ctrl import bbcm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (sts.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            case (sts.func)
               FN_LOOKUP:  state_in = sts.dev_zero ? ST_WALK_RD : ST_FIND;
               FN_DISCARD: state_in = sts.dev_zero ? ST_RESP : ST_FIND;
               FN_INVAL:   state_in = ST_FIND;
               FN_RELEASE, FN_DIRTY, FN_START, FN_FINISH:
                  state_in = sts.bad_slot ? ST_RESP : ST_SLOT_RD;
               default:    state_in = ST_RESP;
            endcase
         end
         ST_FIND: begin
            if (sts.scan_hit) begin
               state_in = ST_RESP;
            end else if (sts.scan_last) begin
               if (sts.func == FN_LOOKUP) state_in = ST_WALK_RD;
               else if (sts.func == FN_INVAL) state_in = ST_INV2;
               else state_in = ST_RESP;
            end
         end
         ST_INV2: begin
            if (sts.scan_last) state_in = ST_RESP;
         end
         ST_SLOT_RD:  state_in = ST_SLOT_EX;
         ST_SLOT_EX:  state_in = ST_RESP;
         ST_WALK_RD:  state_in = ST_WALK_EV;
         ST_WALK_EV:  state_in = sts.walk_stop ? ST_WALK_END : ST_WALK_RD;
         ST_WALK_END: state_in = sts.claim ? ST_MV1 : ST_RESP;
         ST_MV1:      state_in = ST_MV2;
         ST_MV2:      state_in = ST_MV3;
         ST_MV3:      state_in = ST_MV4;
         ST_MV4:      state_in = ST_RESP;
         ST_RESP: begin
            if (sts.rsp_free) state_in = ST_IDLE;
         end
         default:     state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd          = '0;
      cmd.ready    = (state_ff == ST_IDLE);
      cmd.load     = (state_ff == ST_IDLE) && req_valid;
      cmd.clear    = (state_ff == ST_CLEAR);
      cmd.dispatch = (state_ff == ST_DISPATCH);
      cmd.find     = (state_ff == ST_FIND);
      cmd.inv2     = (state_ff == ST_INV2);
      cmd.slot_rd  = (state_ff == ST_SLOT_RD);
      cmd.slot_ex  = (state_ff == ST_SLOT_EX);
      cmd.walk_rd  = (state_ff == ST_WALK_RD);
      cmd.walk_ev  = (state_ff == ST_WALK_EV);
      cmd.walk_end = (state_ff == ST_WALK_END);
      cmd.mv1      = (state_ff == ST_MV1);
      cmd.mv2      = (state_ff == ST_MV2);
      cmd.mv3      = (state_ff == ST_MV3);
      cmd.mv4      = (state_ff == ST_MV4);
      cmd.resp     = (state_ff == ST_RESP);
   end

`ifndef SYNTHESIS
   a_accept_dispatch: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == ST_DISPATCH)
      else $error("accepted request not dispatched");

   a_clear_once: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_CLEAR |=> state_ff != ST_CLEAR)
      else $error("clearing pass re-entered");

   a_relink_seq: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MV1 |=> state_ff == ST_MV2 ##1 state_ff == ST_MV3)
      else $error("ring relink sequence broken");
`endif

endmodule

// ----- hdl/bbcm_datapath.sv -----
// ----------------------------------------------------------------------------
// bbcm_datapath
// Slot tables, ring links, scan and walk registers, result register.
// ----------------------------------------------------------------------------
module bbcm_datapath import bbcm_pkg::*; #(
   parameter int ENTRIES = ENTRIES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output sts_type           sts,
   input  logic [FUNC_W-1:0] req_func,
   input  logic [DEV_W-1:0]  req_device,
   input  logic [BLK_W-1:0]  req_block,
   input  logic [SLOT_W-1:0] req_slot,
   input  logic              req_is_write,
   input  logic              req_transfer_ok,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data
);

   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CW = $clog2(ENTRIES + 1);
   localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);
   localparam logic [CW-1:0] LAST_CNT = CW'(ENTRIES - 1);
   localparam logic [CW-1:0] END_CNT  = CW'(ENTRIES);

   // tables
   logic [DEV_W-1:0] tdev_mem [ENTRIES];
   logic [BLK_W-1:0] tblk_mem [ENTRIES];
   logic [REF_W-1:0] ref_mem  [ENTRIES];
   flags_type        flg_mem  [ENTRIES];
   logic [IW-1:0]    nxt_mem  [ENTRIES];
   logic [IW-1:0]    prv_mem  [ENTRIES];

   logic [DEV_W-1:0] tdev_rd_ff;
   logic [BLK_W-1:0] tblk_rd_ff;
   logic [REF_W-1:0] ref_rd_ff;
   flags_type        flg_rd_ff;
   logic [IW-1:0]    nxt_rd_ff, prv_rd_ff;

   logic [IW-1:0]    rd_addr, rec_waddr, nxt_waddr, prv_waddr;
   logic             tdev_we, tblk_we, ref_we, flg_we, nxt_we, prv_we;
   logic [DEV_W-1:0] tdev_wd;
   logic [BLK_W-1:0] tblk_wd;
   logic [REF_W-1:0] ref_wd;
   flags_type        flg_wd;
   logic [IW-1:0]    nxt_wd, prv_wd;

   // latched request
   logic [FUNC_W-1:0] func_ff;
   logic [DEV_W-1:0]  dev_ff;
   logic [BLK_W-1:0]  blk_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic              wr_ff, ok_ff;

   // scan, walk and result registers
   logic [CW-1:0]    cnt_ff, cnt_in, k_ff, k_in;
   logic             pv_ff, pv_in, have_ff, have_in;
   logic [IW-1:0]    pidx_ff, pidx_in, head_ff, head_in, cur_ff, cur_in;
   logic [IW-1:0]    best_ff, best_in, bnext_ff, bnext_in, bprev_ff, bprev_in;
   logic [1:0]       bbad_ff, bbad_in;
   flags_type        bflg_ff, bflg_in;
   logic [DEV_W-1:0] bdev_ff, bdev_in;
   logic [BLK_W-1:0] bblk_ff, bblk_in;
   rsp_type          res_ff, res_in, rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic [IW-1:0] slot_idx, clr_idx;
   logic          issue, dev_m, blk_m, hit_m, cand;
   logic [1:0]    bad;
   flags_type     fnew;

   function automatic rsp_type mk(rstat_type st, logic show, logic [IW-1:0] s,
                                  logic v, logic b, logic [DEV_W-1:0] vd,
                                  logic [BLK_W-1:0] vb);
      rsp_type r;
      r.status = st;
      r.slot   = show ? SLOT_W'(s) : '0;
      r.valid  = show & v;
      r.busy   = show & b;
      r.vdev   = vd;
      r.vblk   = vb;
      return r;
   endfunction

   assign slot_idx = IW'(slot_ff);
   assign clr_idx  = cnt_ff[IW-1:0];
   assign issue    = (cnt_ff < END_CNT);
   assign dev_m    = (tdev_rd_ff == dev_ff);
   assign blk_m    = (tblk_rd_ff == blk_ff);
   assign hit_m    = cmd.inv2 ? dev_m :
                     (func_ff == FN_INVAL) ? (dev_m && flg_rd_ff.busy) : (dev_m && blk_m);
   assign bad      = {flg_rd_ff.dirty, flg_rd_ff.busy};
   assign cand     = (ref_rd_ff == '0) && (!have_ff || (bad < bbad_ff));

   always_comb begin
      sts            = '0;
      sts.clear_last = (cnt_ff == LAST_CNT);
      sts.func       = func_ff;
      sts.bad_slot   = (32'(slot_ff) >= 32'(ENTRIES));
      sts.dev_zero   = (dev_ff == '0);
      sts.scan_hit   = pv_ff && hit_m;
      sts.scan_last  = pv_ff && (pidx_ff == LAST_IDX);
      sts.walk_stop  = (cand && (bad == 2'b00)) || (k_ff == LAST_CNT);
      sts.claim      = have_ff && !bflg_ff.busy && !bflg_ff.dirty;
      sts.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      rd_addr   = '0;
      rec_waddr = '0;
      nxt_waddr = '0;
      prv_waddr = '0;
      tdev_we = 1'b0; tblk_we = 1'b0; ref_we = 1'b0;
      flg_we  = 1'b0; nxt_we  = 1'b0; prv_we = 1'b0;
      tdev_wd = '0; tblk_wd = '0; ref_wd = '0; flg_wd = '0; nxt_wd = '0; prv_wd = '0;
      fnew    = flg_rd_ff;
      cnt_in  = cnt_ff;  k_in = k_ff;  pv_in = 1'b0;  pidx_in = pidx_ff;
      have_in = have_ff; head_in = head_ff; cur_in = cur_ff;
      best_in = best_ff; bnext_in = bnext_ff; bprev_in = bprev_ff;
      bbad_in = bbad_ff; bflg_in = bflg_ff; bdev_in = bdev_ff; bblk_in = bblk_ff;
      res_in  = res_ff;  rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (cmd.clear) begin
         rec_waddr = clr_idx;
         tdev_we = 1'b1; tblk_we = 1'b1; ref_we = 1'b1; flg_we = 1'b1;
         nxt_we = 1'b1; nxt_waddr = clr_idx;
         nxt_wd = (clr_idx == LAST_IDX) ? '0 : clr_idx + 1'b1;
         prv_we = 1'b1; prv_waddr = clr_idx;
         prv_wd = (clr_idx == '0) ? LAST_IDX : clr_idx - 1'b1;
         cnt_in = cnt_ff + 1'b1;
      end

      if (cmd.load) begin
         cnt_in  = '0;
         k_in    = '0;
         have_in = 1'b0;
         cur_in  = head_ff;
      end

      if (cmd.dispatch) begin
         case (func_ff)
            FN_LOOKUP, FN_INVAL: ;
            FN_DISCARD:
               res_in = mk(RS_NOTHING, 1'b0, '0, 1'b0, 1'b0, '0, '0);
            FN_RELEASE, FN_DIRTY, FN_START, FN_FINISH:
               res_in = mk(RS_MISUSE, 1'b0, '0, 1'b0, 1'b0, '0, '0);
            default:
               res_in = mk(RS_MISUSE, 1'b0, '0, 1'b0, 1'b0, '0, '0);
         endcase
      end

      // tag scan: one read issued a cycle, compared in the cycle after its issue
      if (cmd.find || cmd.inv2) begin
         rd_addr = issue ? clr_idx : '0;
         if (issue) begin
            cnt_in  = cnt_ff + 1'b1;
            pv_in   = 1'b1;
            pidx_in = clr_idx;
         end
      end

      if (cmd.find) begin
         if (pv_ff && hit_m) begin
            rec_waddr = pidx_ff;
            case (func_ff)
               FN_LOOKUP: begin
                  if (ref_rd_ff == REF_MAX) begin
                     res_in = mk(RS_MISUSE, 1'b0, '0, 1'b0, 1'b0, '0, '0);
                  end else begin
                     ref_we = 1'b1;
                     ref_wd = ref_rd_ff + 1'b1;
                     res_in = mk(RS_HIT, 1'b1, pidx_ff, flg_rd_ff.valid,
                                 flg_rd_ff.busy, '0, '0);
                  end
               end
               FN_DISCARD: begin
                  if (flg_rd_ff.busy) begin
                     res_in = mk(RS_BUSY, 1'b1, pidx_ff, flg_rd_ff.valid, 1'b1, '0, '0);
                  end else begin
                     flg_we = 1'b1;
                     res_in = mk(RS_DONE, 1'b1, pidx_ff, 1'b0, 1'b0, '0, '0);
                  end
               end
               default:
                  res_in = mk(RS_BUSY, 1'b1, pidx_ff, flg_rd_ff.valid, 1'b1, '0, '0);
            endcase
         end else if (pv_ff && (pidx_ff == LAST_IDX)) begin
            if (func_ff == FN_DISCARD)
               res_in = mk(RS_NOTHING, 1'b0, '0, 1'b0, 1'b0, '0, '0);
            if (func_ff == FN_INVAL)
               cnt_in = '0;
         end
      end

      if (cmd.inv2) begin
         if (pv_ff && dev_m) begin
            rec_waddr = pidx_ff;
            flg_we    = 1'b1;
         end
         if (pv_ff && (pidx_ff == LAST_IDX))
            res_in = mk(RS_DONE, 1'b0, '0, 1'b0, 1'b0, '0, '0);
      end

      if (cmd.slot_rd)
         rd_addr = slot_idx;

      if (cmd.slot_ex) begin
         rec_waddr = slot_idx;
         case (func_ff)
            FN_RELEASE: begin
               if (flg_rd_ff.busy) begin
                  res_in = mk(RS_BUSY, 1'b1, slot_idx, flg_rd_ff.valid, 1'b1, '0, '0);
               end else if (ref_rd_ff == '0) begin
                  res_in = mk(RS_MISUSE, 1'b0, '0, 1'b0, 1'b0, '0, '0);
               end else begin
                  ref_we = 1'b1;
                  ref_wd = ref_rd_ff - 1'b1;
                  res_in = mk(RS_DONE, 1'b1, slot_idx, flg_rd_ff.valid, 1'b0, '0, '0);
               end
            end
            FN_DIRTY: begin
               fnew.dirty = 1'b1;
               flg_we = 1'b1;
               flg_wd = fnew;
               res_in = mk(RS_DONE, 1'b1, slot_idx, flg_rd_ff.valid, flg_rd_ff.busy,
                           '0, '0);
            end
            FN_START: begin
               if (flg_rd_ff.busy) begin
                  res_in = mk(RS_BUSY, 1'b1, slot_idx, flg_rd_ff.valid, 1'b1, '0, '0);
               end else if ((!wr_ff && flg_rd_ff.valid) || (wr_ff && !flg_rd_ff.dirty)) begin
                  res_in = mk(RS_NOTHING, 1'b1, slot_idx, flg_rd_ff.valid, 1'b0, '0, '0);
               end else begin
                  fnew.busy = 1'b1;
                  if (wr_ff) fnew.dirty = 1'b0;
                  flg_we = 1'b1;
                  flg_wd = fnew;
                  res_in = mk(RS_DONE, 1'b1, slot_idx, flg_rd_ff.valid, 1'b1, '0, '0);
               end
            end
            default: begin
               if (!flg_rd_ff.busy) begin
                  res_in = mk(RS_MISUSE, 1'b0, '0, 1'b0, 1'b0, '0, '0);
               end else begin
                  fnew.busy  = 1'b0;
                  fnew.valid = flg_rd_ff.valid | ok_ff;
                  flg_we = 1'b1;
                  flg_wd = fnew;
                  res_in = mk(RS_DONE, 1'b1, slot_idx, fnew.valid, 1'b0, '0, '0);
               end
            end
         endcase
      end

      // replacement walk: each ring step reads a slot (walk_rd), then weighs it (walk_ev)
      if (cmd.walk_rd)
         rd_addr = cur_ff;

      if (cmd.walk_ev) begin
         if (cand) begin
            have_in  = 1'b1;
            best_in  = cur_ff;
            bbad_in  = bad;
            bflg_in  = flg_rd_ff;
            bdev_in  = tdev_rd_ff;
            bblk_in  = tblk_rd_ff;
            bnext_in = nxt_rd_ff;
            bprev_in = prv_rd_ff;
         end
         cur_in = nxt_rd_ff;
         k_in   = k_ff + 1'b1;
      end

      if (cmd.walk_end) begin
         if (!have_ff)
            res_in = mk(RS_NO_FREE, 1'b0, '0, 1'b0, 1'b0, '0, '0);
         else if (bflg_ff.busy)
            res_in = mk(RS_BUSY, 1'b1, best_ff, bflg_ff.valid, 1'b1, '0, '0);
         else if (bflg_ff.dirty)
            res_in = mk(RS_DIRTY, 1'b1, best_ff, bflg_ff.valid, 1'b0, bdev_ff, bblk_ff);
      end

      // claim and move to ring tail
      if (cmd.mv1) begin
         rec_waddr = best_ff;
         tdev_we = 1'b1; tdev_wd = dev_ff;
         tblk_we = 1'b1; tblk_wd = blk_ff;
         ref_we  = 1'b1; ref_wd  = REF_W'(1);
         flg_we  = 1'b1;
         nxt_we = 1'b1; nxt_waddr = bprev_ff; nxt_wd = bnext_ff;
         prv_we = 1'b1; prv_waddr = bnext_ff; prv_wd = bprev_ff;
         if (head_ff == best_ff) head_in = bnext_ff;
      end

      if (cmd.mv2)
         rd_addr = head_ff;

      if (cmd.mv3) begin
         nxt_we = 1'b1; nxt_waddr = prv_rd_ff; nxt_wd = best_ff;
         prv_we = 1'b1; prv_waddr = best_ff;   prv_wd = prv_rd_ff;
      end

      if (cmd.mv4) begin
         nxt_we = 1'b1; nxt_waddr = best_ff; nxt_wd = head_ff;
         prv_we = 1'b1; prv_waddr = head_ff; prv_wd = best_ff;
         res_in = mk(RS_CLAIMED, 1'b1, best_ff, 1'b0, 1'b0, '0, '0);
      end

      if (cmd.resp && sts.rsp_free) begin
         rsp_in       = res_ff;
         rsp_valid_in = 1'b1;
      end
   end

   // table ports
   always_ff @(posedge clock) begin
      if (tdev_we) tdev_mem[rec_waddr] <= tdev_wd;
      if (tblk_we) tblk_mem[rec_waddr] <= tblk_wd;
      if (ref_we)  ref_mem[rec_waddr]  <= ref_wd;
      if (flg_we)  flg_mem[rec_waddr]  <= flg_wd;
      if (nxt_we)  nxt_mem[nxt_waddr]  <= nxt_wd;
      if (prv_we)  prv_mem[prv_waddr]  <= prv_wd;
      tdev_rd_ff <= tdev_mem[rd_addr];
      tblk_rd_ff <= tblk_mem[rd_addr];
      ref_rd_ff  <= ref_mem[rd_addr];
      flg_rd_ff  <= flg_mem[rd_addr];
      nxt_rd_ff  <= nxt_mem[rd_addr];
      prv_rd_ff  <= prv_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         pv_ff        <= 1'b0;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         pv_ff        <= pv_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= req_func;
         dev_ff  <= req_device;
         blk_ff  <= req_block;
         slot_ff <= req_slot;
         wr_ff   <= req_is_write;
         ok_ff   <= req_transfer_ok;
      end
      k_ff     <= k_in;
      have_ff  <= have_in;
      pidx_ff  <= pidx_in;
      cur_ff   <= cur_in;
      best_ff  <= best_in;
      bnext_ff <= bnext_in;
      bprev_ff <= bprev_in;
      bbad_ff  <= bbad_in;
      bflg_ff  <= bflg_in;
      bdev_ff  <= bdev_in;
      bblk_ff  <= bblk_in;
      res_ff   <= res_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- hdl/block_buffer_cache_manager_top.sv -----
// ----------------------------------------------------------------------------
// block_buffer_cache_manager_top
// Tag and replacement manager for a block buffer cache.
// ----------------------------------------------------------------------------
// One request in, one response out, one request at a time. After reset the
// block runs a clearing pass over every slot of its tables (tags, ref counts,
// flags and the replacement ring) and takes no request until it ends. Slot
// operations (release, mark dirty, start/finish transfer) read the slot, then
// update it. Lookup and discard scan the tag table one slot a cycle, ending
// early on a hit; a lookup miss then walks the ring, reading then weighing
// each slot, over at most ENTRIES slots, and a claim relinks the ring. An
// invalidate scans for a busy slot of the device, then rescans to clear the
// device's slots if none is busy. All slot tables share a single read port.
// A new request may be accepted while the previous response still waits.
// ----------------------------------------------------------------------------
module block_buffer_cache_manager_top import bbcm_pkg::*; #(
   parameter int ENTRIES = ENTRIES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [FUNC_W-1:0] req_func,
   input  logic [DEV_W-1:0]  req_device,
   input  logic [BLK_W-1:0]  req_block,
   input  logic [SLOT_W-1:0] req_slot,
   input  logic              req_is_write,
   input  logic              req_transfer_ok,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [2:0]        rsp_status,
   output logic [SLOT_W-1:0] rsp_result_slot,
   output logic              rsp_slot_valid,
   output logic              rsp_slot_busy,
   output logic [DEV_W-1:0]  rsp_victim_device,
   output logic [BLK_W-1:0]  rsp_victim_block
);

   cmd_type cmd;
   sts_type sts;
   rsp_type rsp_data;

   bbcm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .sts       (sts),
      .cmd       (cmd)
   );

   bbcm_datapath #(
      .ENTRIES (ENTRIES)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_func        (req_func),
      .req_device      (req_device),
      .req_block       (req_block),
      .req_slot        (req_slot),
      .req_is_write    (req_is_write),
      .req_transfer_ok (req_transfer_ok),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data        (rsp_data)
   );

   assign req_ready         = cmd.ready;
   assign rsp_status        = rsp_data.status;
   assign rsp_result_slot   = rsp_data.slot;
   assign rsp_slot_valid    = rsp_data.valid;
   assign rsp_slot_busy     = rsp_data.busy;
   assign rsp_victim_device = rsp_data.vdev;
   assign rsp_victim_block  = rsp_data.vblk;

`ifndef SYNTHESIS
   // victim tag only travels with a dirty victim
   a_victim_tag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != RS_DIRTY) |->
         (rsp_victim_device == '0) && (rsp_victim_block == '0))
      else $error("victim tag on non-dirty response");

   // misuse and no-free carry nothing else
   a_bare_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_data.status == RS_MISUSE) || (rsp_data.status == RS_NO_FREE)) |->
         (rsp_result_slot == '0) && !rsp_slot_valid && !rsp_slot_busy)
      else $error("misuse or no-free response carries slot data");

   // a claimed slot is never shown valid or busy
   a_claim_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == RS_CLAIMED) |-> !rsp_slot_valid && !rsp_slot_busy)
      else $error("claimed slot shown valid or busy");
`endif

endmodule
